// File: design/rhcs_pkg.sv
// ----------------------------------------------------------------------------
// rhcs_pkg
// Shared types and constants for the RTP header check and statistics block.
// ----------------------------------------------------------------------------
package rhcs_pkg;

   localparam int VER_W      = 2;
   localparam int PT_W       = 7;
   localparam int SEQ_W      = 16;
   localparam int TS_W       = 32;
   localparam int SIZE_W     = 16;
   localparam int RATE_W     = 19;
   localparam int NS_W       = 30;
   localparam int CNT_W      = 32;
   localparam int BYTES_W    = 48;
   localparam int PRES_W     = TS_W + NS_W;
   localparam int STEP_W     = $clog2(PRES_W);

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 256;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int MAX_PAYLOAD_DEF = 1500;

   localparam logic [VER_W-1:0]  RTP_VERSION_OK = 2'd2;
   localparam logic [NS_W-1:0]   NS_PER_SEC     = 30'd1000000000;
   localparam logic [PT_W-1:0]   PT_RESET       = 7'd96;
   localparam logic [RATE_W-1:0] RATE_RESET     = 19'd48000;
   localparam logic [CNT_W-1:0]  CNT_MAX        = '1;
   localparam logic [BYTES_W-1:0] BYTES_MAX     = '1;

   // register word select, address bit 2
   localparam logic REG_PT   = 1'b0;
   localparam logic REG_RATE = 1'b1;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_stat_type;

endpackage

// File: design/rhcs_csr.sv
// ----------------------------------------------------------------------------
// rhcs_csr
// Configuration registers: expected payload type and sample rate.
// ----------------------------------------------------------------------------
module rhcs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rhcs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rhcs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rhcs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [rhcs_pkg::PT_W-1:0]         exp_pt,
   output logic [rhcs_pkg::RATE_W-1:0]       sample_rate
);
   import rhcs_pkg::*;

   logic [PT_W-1:0]   exp_pt_ff;
   logic [RATE_W-1:0] rate_ff;
   logic              wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_pt_ff <= PT_RESET;
         rate_ff   <= RATE_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            REG_PT:   exp_pt_ff <= csr_pwdata[PT_W-1:0];
            REG_RATE: rate_ff   <= csr_pwdata[RATE_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PT:   csr_prdata = CSR_DATA_W'(exp_pt_ff);
         REG_RATE: csr_prdata = CSR_DATA_W'(rate_ff);
         default:  csr_prdata = '0;
      endcase
   end

   assign exp_pt      = exp_pt_ff;
   assign sample_rate = rate_ff;

endmodule

// File: design/rhcs_ctrl.sv
// ----------------------------------------------------------------------------
// rhcs_ctrl
// Controller: header accept, multiply, serial divide and result hand-off.
// ----------------------------------------------------------------------------
module rhcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  rhcs_pkg::dp_stat_type  stat,
   output rhcs_pkg::ctrl_cmd_type cmd
);
   import rhcs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign rsp_tvalid   = rsp_valid_ff;

   assign cmd.load     = accept;
   assign cmd.mul      = (state_ff == ST_MUL);
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = stat.need_div ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(PRES_W - 1)) state_in = ST_DONE;
            else step_in = step_ff + STEP_W'(1);
         end
         ST_DONE: begin
            if (cmd.out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("header accepted while previous one still in work");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before taken");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < STEP_W'(PRES_W)))
      else $error("divide step count out of range");
`endif

endmodule

// File: design/rhcs_dpath.sv
// ----------------------------------------------------------------------------
// rhcs_dpath
// Datapath: header checks, saturating counters, timestamp baseline,
// delta multiply and restoring divide by the sample rate.
// ----------------------------------------------------------------------------
module rhcs_dpath #(
   parameter int MAX_PAYLOAD = rhcs_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rhcs_pkg::ctrl_cmd_type          cmd,
   output rhcs_pkg::dp_stat_type           stat,
   input  logic [rhcs_pkg::PT_W-1:0]       exp_pt,
   input  logic [rhcs_pkg::RATE_W-1:0]     sample_rate,
   input  logic [rhcs_pkg::VER_W-1:0]      rtp_version,
   input  logic [rhcs_pkg::PT_W-1:0]       payload_type,
   input  logic [rhcs_pkg::SEQ_W-1:0]      sequence_req,
   input  logic [rhcs_pkg::TS_W-1:0]       rtp_timestamp,
   input  logic [rhcs_pkg::SIZE_W-1:0]     payload_bytes,
   output logic                            accepted,
   output logic [rhcs_pkg::SEQ_W-1:0]      out_sequence,
   output logic                            first_packet,
   output logic [rhcs_pkg::PRES_W-1:0]     presentation_ns,
   output logic [rhcs_pkg::CNT_W-1:0]      received_count,
   output logic [rhcs_pkg::CNT_W-1:0]      lost_count,
   output logic [rhcs_pkg::CNT_W-1:0]      reorder_count,
   output logic [rhcs_pkg::CNT_W-1:0]      malformed_count,
   output logic [rhcs_pkg::BYTES_W-1:0]    byte_count
);
   import rhcs_pkg::*;

   // statistics state
   logic [SEQ_W-1:0]   last_seq_ff;
   logic [TS_W-1:0]    base_ts_ff;
   logic               base_valid_ff;
   logic [CNT_W-1:0]   recv_ff, lost_ff, reord_ff, malf_ff;
   logic [BYTES_W-1:0] bytes_ff;

   // per-header work registers
   logic               acc_ff, first_ff, div_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [TS_W-1:0]    delta_ff;
   logic [PRES_W-1:0]  dvd_ff;
   logic [RATE_W-1:0]  rem_ff;

   // result register
   logic               out_acc_ff, out_first_ff;
   logic [SEQ_W-1:0]   out_seq_ff;
   logic [PRES_W-1:0]  out_pres_ff;
   logic [CNT_W-1:0]   out_recv_ff, out_lost_ff, out_reord_ff, out_malf_ff;
   logic [BYTES_W-1:0] out_bytes_ff;

   logic               hdr_ok, is_first, gap_fwd, seq_match;
   logic [SEQ_W-1:0]   expect_seq, gap;
   logic [CNT_W:0]     recv_sum, lost_sum, reord_sum, malf_sum;
   logic [BYTES_W:0]   bytes_sum;
   logic [RATE_W:0]    trial, trial_sub;

   always_comb begin
      hdr_ok     = (rtp_version == RTP_VERSION_OK) && (payload_type == exp_pt) &&
                   (payload_bytes != '0) && (payload_bytes <= SIZE_W'(MAX_PAYLOAD));
      is_first   = (recv_ff == '0);
      expect_seq = last_seq_ff + SEQ_W'(1);
      seq_match  = (sequence_req == expect_seq);
      gap        = sequence_req - expect_seq;
      gap_fwd    = !gap[SEQ_W-1];
      recv_sum   = {1'b0, recv_ff} + (CNT_W+1)'(1);
      lost_sum   = {1'b0, lost_ff} + (CNT_W+1)'(gap);
      reord_sum  = {1'b0, reord_ff} + (CNT_W+1)'(1);
      malf_sum   = {1'b0, malf_ff} + (CNT_W+1)'(1);
      bytes_sum  = {1'b0, bytes_ff} + (BYTES_W+1)'(payload_bytes);
      stat.need_div = hdr_ok && (sample_rate != '0) && base_valid_ff;
      trial      = {rem_ff, dvd_ff[PRES_W-1]};
      trial_sub  = trial - {1'b0, sample_rate};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff   <= '0;
         base_ts_ff    <= '0;
         base_valid_ff <= 1'b0;
         recv_ff       <= '0;
         lost_ff       <= '0;
         reord_ff      <= '0;
         malf_ff       <= '0;
         bytes_ff      <= '0;
      end else if (cmd.load) begin
         if (!hdr_ok) begin
            malf_ff <= malf_sum[CNT_W] ? CNT_MAX : malf_sum[CNT_W-1:0];
         end else begin
            if (!is_first && !seq_match) begin
               if (gap_fwd) lost_ff <= lost_sum[CNT_W] ? CNT_MAX : lost_sum[CNT_W-1:0];
               else reord_ff <= reord_sum[CNT_W] ? CNT_MAX : reord_sum[CNT_W-1:0];
            end
            last_seq_ff <= sequence_req;
            recv_ff     <= recv_sum[CNT_W] ? CNT_MAX : recv_sum[CNT_W-1:0];
            bytes_ff    <= bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
            if ((sample_rate != '0) && !base_valid_ff) begin
               base_ts_ff    <= rtp_timestamp;
               base_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff   <= hdr_ok;
         first_ff <= hdr_ok && is_first;
         div_ff   <= stat.need_div;
         seq_ff   <= sequence_req;
         delta_ff <= rtp_timestamp - base_ts_ff;
      end
      if (cmd.mul) begin
         dvd_ff <= PRES_W'(delta_ff) * PRES_W'(NS_PER_SEC);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial_sub[RATE_W]) begin
            rem_ff <= trial_sub[RATE_W-1:0];
            dvd_ff <= {dvd_ff[PRES_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[RATE_W-1:0];
            dvd_ff <= {dvd_ff[PRES_W-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         out_acc_ff   <= acc_ff;
         out_first_ff <= first_ff;
         out_seq_ff   <= seq_ff;
         out_pres_ff  <= div_ff ? dvd_ff : '0;
         out_recv_ff  <= recv_ff;
         out_lost_ff  <= lost_ff;
         out_reord_ff <= reord_ff;
         out_malf_ff  <= malf_ff;
         out_bytes_ff <= bytes_ff;
      end
   end

   assign accepted        = out_acc_ff;
   assign out_sequence    = out_seq_ff;
   assign first_packet    = out_first_ff;
   assign presentation_ns = out_pres_ff;
   assign received_count  = out_recv_ff;
   assign lost_count      = out_lost_ff;
   assign reorder_count   = out_reord_ff;
   assign malformed_count = out_malf_ff;
   assign byte_count      = out_bytes_ff;

`ifndef NO_ASSERTIONS
   a_rem_below_rate: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (rem_ff < sample_rate))
      else $error("divide remainder not below sample rate");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && !acc_ff) |=> (out_pres_ff == '0) && !out_first_ff)
      else $error("rejected header carries time or first flag");
   a_div_needs_base: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && stat.need_div) |-> base_valid_ff && (sample_rate != '0))
      else $error("divide started without baseline");
`endif

endmodule

// File: design/rtp_header_check_and_stats.sv
// flow: with no divide needed (rejected header, zero sample rate, baseline
// packet) the header goes straight to the result register, else through
// a multiply step and 62 serial divide steps of 1 quotient bit each
// handshake: a new header is taken only once the result register is loaded
// reset: synchronous, active high; counters and baseline clear, registers
// return to payload type 96 and sample rate 48000
// ----------------------------------------------------------------------------
// rtp_header_check_and_stats
// RTP header check, sequence tracking, statistics and presentation time.
// ----------------------------------------------------------------------------
module rtp_header_check_and_stats #(
   parameter int MAX_PAYLOAD = rhcs_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // version[1:0], payload_type[8:2], sequence_req[24:9],
   // rtp_timestamp[56:25], payload_bytes[72:57], zero fill
   input  logic [rhcs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // out_sequence[15:0], presentation_ns[77:16], received_count[109:78],
   // lost_count[141:110], reorder_count[173:142], malformed_count[205:174],
   // byte_count[253:206], zero fill
   output logic [rhcs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // accepted[0], first_packet[1]
   output logic [rhcs_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rhcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rhcs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rhcs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import rhcs_pkg::*;

   ctrl_cmd_type       cmd;
   dp_stat_type        stat;
   logic [PT_W-1:0]    exp_pt;
   logic [RATE_W-1:0]  sample_rate;
   logic               accepted, first_packet;
   logic [SEQ_W-1:0]   out_sequence;
   logic [PRES_W-1:0]  presentation_ns;
   logic [CNT_W-1:0]   received_count, lost_count, reorder_count, malformed_count;
   logic [BYTES_W-1:0] byte_count;

   rhcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .exp_pt      (exp_pt),
      .sample_rate (sample_rate)
   );

   rhcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rhcs_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .exp_pt          (exp_pt),
      .sample_rate     (sample_rate),
      .rtp_version     (req_tdata[1:0]),
      .payload_type    (req_tdata[8:2]),
      .sequence_req    (req_tdata[24:9]),
      .rtp_timestamp   (req_tdata[56:25]),
      .payload_bytes   (req_tdata[72:57]),
      .accepted        (accepted),
      .out_sequence    (out_sequence),
      .first_packet    (first_packet),
      .presentation_ns (presentation_ns),
      .received_count  (received_count),
      .lost_count      (lost_count),
      .reorder_count   (reorder_count),
      .malformed_count (malformed_count),
      .byte_count      (byte_count)
   );

   assign rsp_tdata = {2'b00, byte_count, malformed_count, reorder_count, lost_count,
                       received_count, presentation_ns, out_sequence};
   assign rsp_tuser = {first_packet, accepted};

endmodule
